// ===== src/dual_queue_shared_buffer_top_macros.svh =====
// Assertion helpers for the top file, which checks its own logic.
`ifndef DUAL_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH
`define DUAL_QUEUE_SHARED_BUFFER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DQSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that one condition is followed by another in the next cycle.
`define DQSB_ASSERT_NEXT(label, cond, next, msg) \
    `DQSB_ASSERT(label, (cond) |=> (next), msg)

`endif

// ===== src/dqsb_pkg.sv =====
package dqsb_pkg;

    localparam int CFG_BITS      = 11;
    localparam int CAP_RESET     = 1024;
    localparam int DEPTH_DEF     = 1024;
    localparam int DATA_BITS_DEF = 32;
    localparam int WORD_BITS     = 32;

    typedef enum logic [2:0] {
        MODE_ENQ_A  = 3'd0,
        MODE_DEQ_A  = 3'd1,
        MODE_PEEK_A = 3'd2,
        MODE_ENQ_B  = 3'd3,
        MODE_DEQ_B  = 3'd4,
        MODE_PEEK_B = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Memory access and outcome decided for one transaction.
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        t_status status;
    } t_access;

endpackage

// ===== src/dual_queue_shared_buffer_top.sv =====
// Two FIFO queues sharing one word store. Queue A fills upward from slot 0,
// queue B fills downward from slot capacity-1, and an enqueue is refused as
// full when the two tails would meet. Each transaction (start high while busy
// is low) enqueues, dequeues or peeks on one queue and produces exactly one
// result, shown on o_read_value and o_status for a single cycle with o_strobe
// high, in the cycle after the transaction is taken. The receiver cannot stall
// it, so capture the result on that cycle. The block takes one transaction
// every clock: pointers update at the accepting edge and the store read is
// registered, and an enqueue followed at once by a dequeue of the same slot
// reads the freshly written word. busy is high only during reset and until
// the first clock edge after it. Freed slots are not reused until their
// queue drains empty, at which point its pointers snap back to the start.
// Writing the capacity register empties both queues; a capacity of zero
// acts as one and one beyond DEPTH acts as DEPTH. Errors and enqueues
// return all ones on o_read_value.
module dual_queue_shared_buffer_top #(
    parameter int DEPTH     = dqsb_pkg::DEPTH_DEF,
    parameter int DATA_BITS = dqsb_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     i_mode,
    input  logic signed [dqsb_pkg::WORD_BITS-1:0] i_value,
    input  logic                           i_cfg_we,
    input  logic [dqsb_pkg::CFG_BITS-1:0]  i_cfg_data,
    output logic                           o_strobe,
    output logic signed [dqsb_pkg::WORD_BITS-1:0] o_read_value,
    output logic [1:0]                     o_status
);
    import dqsb_pkg::*;

    `include "dual_queue_shared_buffer_top_macros.svh"

    localparam int AW = $clog2(DEPTH);

    logic                 r_ready;
    logic                 r_valid;
    logic                 r_use_mem;
    t_status              r_status;
    logic [DATA_BITS-1:0] r_rd_data;
    logic [DATA_BITS-1:0] mem [DEPTH];

    logic                 accept;
    t_access              access;
    logic [AW-1:0]        addr;
    logic [63:0]          value_wide;
    logic [63:0]          rd_wide;

    assign busy   = !r_ready;
    assign accept = start && !busy;

    dqsb_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_mode     (i_mode),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_access   (access),
        .o_addr     (addr)
    );

    // Stored words keep the low DATA_BITS of the sign-extended input.
    assign value_wide = 64'(i_value);

    always_ff @(posedge i_clk) begin
        if (accept && access.wr_en) begin
            mem[addr] <= value_wide[DATA_BITS-1:0];
        end
        if (accept && access.rd_en) begin
            r_rd_data <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready   <= 1'b0;
            r_valid   <= 1'b0;
            r_use_mem <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_ready   <= 1'b1;
            r_valid   <= accept;
            r_use_mem <= accept && access.rd_en;
            r_status  <= access.status;
        end
    end

    // Words read back are sign-extended from DATA_BITS to the result width.
    assign rd_wide      = 64'($signed(r_rd_data));
    assign o_strobe     = r_valid;
    assign o_read_value = r_use_mem ? rd_wide[WORD_BITS-1:0] : '1;
    assign o_status     = r_status;

    `DQSB_ASSERT(a_strobe_follows_accept, o_strobe |-> $past(accept), "result without transaction")
    `DQSB_ASSERT_NEXT(a_accept_gives_result, accept, o_strobe, "transaction lost its result")
    `DQSB_ASSERT(a_error_all_ones, (o_strobe && o_status != ST_OK) |-> (o_read_value == '1), "error result is not all ones")

endmodule

// ===== src/dqsb_ctrl.sv =====
module dqsb_ctrl #(
    parameter int DEPTH = dqsb_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [2:0]                    i_mode,
    input  logic                          i_cfg_we,
    input  logic [dqsb_pkg::CFG_BITS-1:0] i_cfg_data,
    output dqsb_pkg::t_access             o_access,
    output logic [$clog2(DEPTH)-1:0]      o_addr
);
    import dqsb_pkg::*;

    // Pointers span minus one up to DEPTH, so they carry a sign bit.
    localparam int PW  = $clog2(DEPTH + 1) + 1;
    localparam int AW  = $clog2(DEPTH);
    localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
    localparam logic signed [PW-1:0] P_NONE = '1;
    localparam logic signed [PW-1:0] P_ZERO = '0;
    localparam logic signed [PW-1:0] P_ONE  = PW'(1);

    logic signed [PW-1:0] r_head_a, r_tail_a, r_head_b, r_tail_b, r_cap;
    logic signed [PW-1:0] n_head_a, n_tail_a, n_head_b, n_tail_b;
    logic signed [PW-1:0] inc_a, dec_b, addr_ptr;
    logic signed [PW-1:0] cap_new;
    logic [31:0]          cfg_wide;
    t_access              acc;

    // Capacity zero acts as one, values beyond the store act as the store size.
    always_comb begin
        cfg_wide = 32'(i_cfg_data);
        if (cfg_wide == 32'd0) begin
            cap_new = P_ONE;
        end else if (cfg_wide > 32'(DEPTH)) begin
            cap_new = PW'(DEPTH);
        end else begin
            cap_new = PW'(cfg_wide);
        end
    end

    always_comb begin
        inc_a      = r_tail_a + P_ONE;
        dec_b      = r_tail_b - P_ONE;
        n_head_a   = r_head_a;
        n_tail_a   = r_tail_a;
        n_head_b   = r_head_b;
        n_tail_b   = r_tail_b;
        addr_ptr   = P_ZERO;
        acc.wr_en  = 1'b0;
        acc.rd_en  = 1'b0;
        acc.status = ST_OK;
        unique case (i_mode) inside
            MODE_ENQ_A: begin
                if (inc_a >= r_tail_b) begin
                    acc.status = ST_FULL;
                end else begin
                    acc.wr_en = 1'b1;
                    addr_ptr  = inc_a;
                    n_tail_a  = inc_a;
                    if (r_head_a == P_NONE) begin
                        n_head_a = P_ZERO;
                    end
                end
            end
            MODE_DEQ_A, MODE_PEEK_A: begin
                if (r_head_a == P_NONE) begin
                    acc.status = ST_EMPTY;
                end else begin
                    acc.rd_en = 1'b1;
                    addr_ptr  = r_head_a;
                    if (i_mode == MODE_DEQ_A) begin
                        if (r_head_a == r_tail_a) begin
                            n_head_a = P_NONE;
                            n_tail_a = P_NONE;
                        end else begin
                            n_head_a = r_head_a + P_ONE;
                        end
                    end
                end
            end
            MODE_ENQ_B: begin
                if (dec_b <= r_tail_a) begin
                    acc.status = ST_FULL;
                end else begin
                    acc.wr_en = 1'b1;
                    addr_ptr  = dec_b;
                    n_tail_b  = dec_b;
                    if (r_head_b == r_cap) begin
                        n_head_b = dec_b;
                    end
                end
            end
            MODE_DEQ_B, MODE_PEEK_B: begin
                if (r_head_b == r_cap) begin
                    acc.status = ST_EMPTY;
                end else begin
                    acc.rd_en = 1'b1;
                    addr_ptr  = r_head_b;
                    if (i_mode == MODE_DEQ_B) begin
                        if (r_head_b == r_tail_b) begin
                            n_head_b = r_cap;
                            n_tail_b = r_cap;
                        end else begin
                            n_head_b = r_head_b - P_ONE;
                        end
                    end
                end
            end
            default: begin
                acc.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= PW'(CAP_RST);
            r_head_a <= P_NONE;
            r_tail_a <= P_NONE;
            r_head_b <= PW'(CAP_RST);
            r_tail_b <= PW'(CAP_RST);
        end else if (i_cfg_we) begin
            r_cap    <= cap_new;
            r_head_a <= P_NONE;
            r_tail_a <= P_NONE;
            r_head_b <= cap_new;
            r_tail_b <= cap_new;
        end else if (i_accept) begin
            r_head_a <= n_head_a;
            r_tail_a <= n_tail_a;
            r_head_b <= n_head_b;
            r_tail_b <= n_tail_b;
        end
    end

    assign o_access = acc;
    assign o_addr   = addr_ptr[AW-1:0];

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for dual_queue_shared_buffer_top.
//
// A driver feeds transactions from a pending queue and holds each one until
// the block takes it. A monitor runs a cycle-level predictor of the two
// queues next to the block. For every accepted transaction it stores the
// expected read value and status, and it compares each strobed result with
// the oldest stored expectation. Capacity writes happen only when nothing
// is in flight, and the predictor reloads its pointers on the same edge.
module testbench;
    import dqsb_pkg::*;

    // Mode codes the block leaves unused. They must give all ones and ok.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTED   = 40;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    typedef struct {
        logic [2:0]                  mode;
        logic signed [WORD_BITS-1:0] value;
    } t_queue_op;

    typedef struct {
        logic [WORD_BITS-1:0] read_value;
        t_status              status;
    } t_queue_result;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [2:0]                    i_mode       = '0;
    logic signed [WORD_BITS-1:0]   i_value      = '0;
    logic                          i_cfg_we     = 1'b0;
    logic [CFG_BITS-1:0]           i_cfg_data   = '0;
    logic                          o_strobe;
    logic signed [WORD_BITS-1:0]   o_read_value;
    logic [1:0]                    o_status;

    dual_queue_shared_buffer_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

    // Transactions waiting to be driven, and results still owed by the block.
    t_queue_op     pending_ops[$];
    t_queue_result expected_results[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Predictor state: the shared word store, both queues' pointers and the
    // capacity as the block actually uses it.
    logic [WORD_BITS-1:0] shadow_slots [DEPTH_DEF];
    int                   used_capacity;
    int                   a_head, a_tail, b_head, b_tail;

    // Set by the monitor at each rising edge when a transaction was taken,
    // read by the driver at the following falling edge.
    logic op_taken = 1'b0;

    // Driver burst shaping.
    int        burst_left = 1;
    int        gap_left   = 0;
    t_queue_op next_op;

    t_queue_op     taken_op;
    t_queue_result observed_exp;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Writing the capacity empties both queues. Zero behaves as one, and
    // anything above the store depth is clipped to the depth.
    function automatic void load_capacity(logic [CFG_BITS-1:0] cap);
        if (cap == 0)
            used_capacity = 1;
        else if (cap > DEPTH_DEF)
            used_capacity = DEPTH_DEF;
        else
            used_capacity = cap;
        a_head = -1;
        a_tail = -1;
        b_head = used_capacity;
        b_tail = used_capacity;
    endfunction

    // Applies one transaction to the predicted queues and returns the result
    // the block owes for it. Queue A grows up from slot 0, queue B grows down
    // from the top, and a queue's pointers snap back only when it drains.
    function automatic t_queue_result predict_queue_op(t_queue_op op);
        t_queue_result res;
        res.read_value = ALL_ONES;
        res.status     = ST_OK;
        case (op.mode)
            MODE_ENQ_A: begin
                if (a_tail + 1 >= b_tail) begin
                    res.status = ST_FULL;
                end else begin
                    if (a_head == -1) begin
                        a_head = 0;
                        a_tail = 0;
                    end else begin
                        a_tail++;
                    end
                    shadow_slots[a_tail] = op.value;
                end
            end
            MODE_DEQ_A, MODE_PEEK_A: begin
                if (a_head == -1) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = shadow_slots[a_head];
                    if (op.mode == MODE_DEQ_A) begin
                        if (a_head == a_tail) begin
                            a_head = -1;
                            a_tail = -1;
                        end else begin
                            a_head++;
                        end
                    end
                end
            end
            MODE_ENQ_B: begin
                if (b_tail - 1 <= a_tail) begin
                    res.status = ST_FULL;
                end else begin
                    if (b_head == used_capacity) begin
                        b_head = used_capacity - 1;
                        b_tail = used_capacity - 1;
                    end else begin
                        b_tail--;
                    end
                    shadow_slots[b_tail] = op.value;
                end
            end
            MODE_DEQ_B, MODE_PEEK_B: begin
                if (b_head == used_capacity) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = shadow_slots[b_head];
                    if (op.mode == MODE_DEQ_B) begin
                        if (b_head == b_tail) begin
                            b_head = used_capacity;
                            b_tail = used_capacity;
                        end else begin
                            b_head--;
                        end
                    end
                end
            end
            default: begin
                // Spare codes change nothing.
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTED)
            $display("[%0d] mismatch: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic logic signed [WORD_BITS-1:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_op(logic [2:0] mode, logic signed [WORD_BITS-1:0] value);
        t_queue_op op;
        op.mode  = mode;
        op.value = value;
        pending_ops.push_back(op);
    endfunction

    // A mix of well-formed traffic: enqueues weighted by enq_pct, the rest
    // dequeues and peeks, with a sprinkle of spare mode codes as noise.
    function automatic void add_random_ops(int count, int enq_pct);
        int         pick;
        logic [2:0] mode;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
            else if (pick < 3 + enq_pct)
                mode = $urandom_range(0, 1) ? MODE_ENQ_A : MODE_ENQ_B;
            else if ($urandom_range(0, 3) == 0)
                mode = $urandom_range(0, 1) ? MODE_PEEK_A : MODE_PEEK_B;
            else
                mode = $urandom_range(0, 1) ? MODE_DEQ_A : MODE_DEQ_B;
            add_op(mode, rand_word());
        end
    endfunction

    // Returns once every queued transaction has been taken and every result
    // it owes has been checked. Sampled at the falling edge so the monitor
    // has already finished with the preceding rising edge.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_ops.size() != 0 || start || expected_results.size() != 0);
    endtask

    // The register is written only with the block idle.
    task automatic write_capacity(logic [CFG_BITS-1:0] cap);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_BITS'($urandom);
    endtask

    // Driver. Transactions go out in bursts of random length separated by
    // random gaps, some of them zero so that back-to-back traffic occurs.
    // A transaction stays on the ports until the block takes it; while idle
    // the payload ports carry junk that the block must ignore.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else if (start && !op_taken) begin
            // Still waiting for the block to take the current transaction.
        end else if (gap_left > 0 || pending_ops.size() == 0) begin
            if (gap_left > 0)
                gap_left--;
            start   <= 1'b0;
            i_mode  <= 3'($urandom);
            i_value <= WORD_BITS'($urandom);
        end else begin
            next_op = pending_ops.pop_front();
            start   <= 1'b1;
            i_mode  <= next_op.mode;
            i_value <= next_op.value;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 2) == 0)
                    gap_left = 0;
                else if ($urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(10, 25);
                else
                    gap_left = $urandom_range(1, 4);
            end
        end
    end

    // Monitor. The result check comes first because a result strobed at this
    // edge belongs to a transaction taken at an earlier edge; only then is the
    // transaction taken at this edge (if any) added to the predicted results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_taken = 1'b0;
            load_capacity(CFG_BITS'(CAP_RESET));
        end else begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: value %h status %0d",
                                              o_read_value, o_status));
                end else begin
                    observed_exp = expected_results.pop_front();
                    if (o_read_value !== observed_exp.read_value)
                        report_mismatch($sformatf("read_value %h, predicted %h",
                                                  o_read_value, observed_exp.read_value));
                    if (o_status !== observed_exp.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  o_status, observed_exp.status));
                end
            end
            if (i_cfg_we)
                load_capacity(i_cfg_data);
            op_taken = start && !busy;
            if (op_taken) begin
                taken_op.mode  = i_mode;
                taken_op.value = i_value;
                expected_results.push_back(predict_queue_op(taken_op));
            end
        end
    end

    // Watchdog for a block that stops answering or never takes a transaction.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** dual_queue_shared_buffer_top: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset capacity: every operation on empty
        // queues, the spare codes, the extreme words, draining each queue so
        // its pointers snap back, and a dequeue right behind its enqueue.
        add_op(MODE_DEQ_A, 32'sh1234_5678);
        add_op(MODE_PEEK_A, '0);
        add_op(MODE_DEQ_B, '1);
        add_op(MODE_PEEK_B, '0);
        add_op(MODE_SPARE_6, 32'sh7FFF_FFFF);
        add_op(MODE_SPARE_7, 32'sh8000_0000);
        add_op(MODE_ENQ_A, 32'sh7FFF_FFFF);
        add_op(MODE_ENQ_A, 32'sh8000_0000);
        add_op(MODE_ENQ_B, '1);
        add_op(MODE_ENQ_B, '0);
        add_op(MODE_PEEK_A, '0);
        add_op(MODE_DEQ_A, '0);
        add_op(MODE_DEQ_A, '0);
        add_op(MODE_DEQ_A, '0);
        add_op(MODE_PEEK_B, '0);
        add_op(MODE_DEQ_B, '0);
        add_op(MODE_DEQ_B, '0);
        add_op(MODE_DEQ_B, '0);
        add_op(MODE_ENQ_A, 32'sh5555_5555);
        add_op(MODE_DEQ_A, '0);
        add_op(MODE_ENQ_B, 32'shAAAA_AAAA);
        add_op(MODE_DEQ_B, '0);
        add_random_ops(250, 55);

        // Smallest capacity: one slot, so either queue fills the store.
        write_capacity(11'd1);
        add_op(MODE_ENQ_A, 32'sh0BAD_F00D);
        add_op(MODE_ENQ_B, 32'sh1111_1111);
        add_op(MODE_ENQ_A, 32'sh2222_2222);
        add_op(MODE_DEQ_A, '0);
        add_op(MODE_ENQ_B, 32'shCAFE_0001);
        add_op(MODE_ENQ_A, 32'sh3333_3333);
        add_op(MODE_PEEK_B, '0);
        add_op(MODE_DEQ_B, '0);
        add_random_ops(60, 55);

        // Zero acts as one; two and three exercise the tails meeting.
        write_capacity(11'd0);
        add_random_ops(60, 55);
        write_capacity(11'd2);
        add_random_ops(80, 55);
        write_capacity(11'd3);
        add_random_ops(80, 55);

        // Out-of-range capacities clip to the store depth.
        write_capacity(11'h7FF);
        add_random_ops(250, 60);
        write_capacity(11'(DEPTH_DEF + 1));
        add_random_ops(150, 50);

        // Moderate capacities where full and empty both come up often.
        for (int p = 0; p < 5; p++) begin
            write_capacity(11'($urandom_range(4, 64)));
            add_random_ops(120, $urandom_range(45, 65));
        end

        write_capacity(11'(DEPTH_DEF));
        add_random_ops(150, 55);

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("** dual_queue_shared_buffer_top: PASSED **");
        end else begin
            $display("** dual_queue_shared_buffer_top: FAILED **");
        end
        $finish;
    end

endmodule
